// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They expand to nothing when SYNTHESIS
// is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked at every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== src/slcan_rp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcan_rp_pkg
// Types, byte codes and helpers shared by the serial CAN reply parser.
// ----------------------------------------------------------------------------
package slcan_rp_pkg;

   localparam logic [7:0] CHAR_BEL = 8'd7;
   localparam logic [7:0] CHAR_CR  = 8'd13;
   localparam logic [7:0] CHAR_N   = 8'h4E;
   localparam logic [7:0] CHAR_V   = 8'h56;
   localparam logic [7:0] CHAR_T_L = 8'h74;
   localparam logic [7:0] CHAR_T_U = 8'h54;
   localparam logic [7:0] CHAR_R_L = 8'h72;
   localparam logic [7:0] CHAR_R_U = 8'h52;

   localparam logic [1:0] HDR_NONE    = 2'd0;
   localparam logic [1:0] HDR_SERIAL  = 2'd1;
   localparam logic [1:0] HDR_VERSION = 2'd2;
   localparam logic [1:0] HDR_FRAME   = 2'd3;

   localparam logic [2:0] EV_OK      = 3'd0;
   localparam logic [2:0] EV_ERROR   = 3'd1;
   localparam logic [2:0] EV_SERIAL  = 3'd2;
   localparam logic [2:0] EV_VERSION = 3'd3;
   localparam logic [2:0] EV_FRAME   = 3'd4;

   localparam logic [3:0] MAX_DLC = 4'd8;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [3:0] hex_digit;
      logic       is_bel;
      logic       is_cr;
      logic [1:0] hdr_code;
      logic       frame_ext;
      logic       frame_rtr;
   } token_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [28:0] frame_id;
      logic        is_extended;
      logic        is_remote;
      logic [3:0]  data_length;
      logic [63:0] payload;
      logic        has_timestamp;
      logic [15:0] timestamp;
      logic [31:0] info_chars;
   } result_type;

   // Non-hex characters count as zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

// ===== src/slcan_rp_front.sv =====
// ----------------------------------------------------------------------------
// slcan_rp_front
// Classifies each received byte: control characters, header letters and
// hex digit value, ready for the parser behind the queue.
// ----------------------------------------------------------------------------
module slcan_rp_front
   import slcan_rp_pkg::*;
(
   input  logic [7:0] rx_byte,
   output token_type  token
);

   always_comb begin
      token           = '0;
      token.rx_byte   = rx_byte;
      token.hex_digit = hex_value(rx_byte);
      token.is_bel    = (rx_byte == CHAR_BEL);
      token.is_cr     = (rx_byte == CHAR_CR);
      case (rx_byte)
         CHAR_N: begin
            token.hdr_code = HDR_SERIAL;
         end
         CHAR_V: begin
            token.hdr_code = HDR_VERSION;
         end
         CHAR_T_L: begin
            token.hdr_code = HDR_FRAME;
         end
         CHAR_T_U: begin
            token.hdr_code  = HDR_FRAME;
            token.frame_ext = 1'b1;
         end
         CHAR_R_L: begin
            token.hdr_code  = HDR_FRAME;
            token.frame_rtr = 1'b1;
         end
         CHAR_R_U: begin
            token.hdr_code  = HDR_FRAME;
            token.frame_ext = 1'b1;
            token.frame_rtr = 1'b1;
         end
         default: begin
            token.hdr_code = HDR_NONE;
         end
      endcase
   end

endmodule

// ===== src/slcan_rp_queue.sv =====
// ----------------------------------------------------------------------------
// slcan_rp_queue
// Short first-in first-out queue of classified bytes between the front and
// the parser, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module slcan_rp_queue
   import slcan_rp_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output token_type head_token
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] ONE_PTR  = PTR_W'(1);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   token_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign not_empty  = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + ONE_PTR;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + ONE_PTR;
      end
      if (push && !pop) begin
         count_in = count_ff + ONE_CNT;
      end else if (pop && !push) begin
         count_in = count_ff - ONE_CNT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

// ===== src/slcan_rp_back.sv =====
// ----------------------------------------------------------------------------
// slcan_rp_back
// Reply parser: walks the header, identifier, length, data and timestamp
// fields one classified byte at a time and loads finished events into the
// response register.
// ----------------------------------------------------------------------------
module slcan_rp_back
   import slcan_rp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pass_frames,
   input  logic       tok_valid,
   input  token_type  tok,
   output logic       tok_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_SERIAL   = 4'd1;
   localparam logic [3:0] PH_VERSION  = 4'd2;
   localparam logic [3:0] PH_ID       = 4'd3;
   localparam logic [3:0] PH_DLC      = 4'd4;
   localparam logic [3:0] PH_DATA     = 4'd5;
   localparam logic [3:0] PH_END      = 4'd6;
   localparam logic [3:0] PH_STAMP    = 4'd7;
   localparam logic [3:0] PH_STAMP_CR = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [28:0] id_ff, id_in;
   logic [3:0]  len_ff, len_in;
   logic [63:0] data_ff, data_in;
   logic        ext_ff, ext_in;
   logic        rtr_ff, rtr_in;
   logic [15:0] stamp_ff, stamp_in;
   logic [31:0] chars_ff, chars_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;

   logic        emit;
   result_type  res;
   logic [4:0]  count_inc;
   logic [3:0]  dlc;
   logic [5:0]  nib_shift;
   logic [3:0]  d;

   // A byte is taken whenever the response register is free or being emptied.
   assign tok_pop   = tok_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign d         = tok.hex_digit;
   assign count_inc = count_ff + 5'd1;
   assign dlc       = (d > MAX_DLC) ? MAX_DLC : d;
   // Each byte is sent high nibble first, and byte i sits in bits 8i+7..8i.
   assign nib_shift = {count_ff[3:1], ~count_ff[0], 2'b00};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      data_in  = data_ff;
      ext_in   = ext_ff;
      rtr_in   = rtr_ff;
      stamp_in = stamp_ff;
      chars_in = chars_ff;
      emit     = 1'b0;
      res      = '0;

      case (phase_ff)
         PH_IDLE: begin
            if (tok.is_bel || tok.is_cr) begin
               emit           = 1'b1;
               res.event_kind = tok.is_bel ? EV_ERROR : EV_OK;
            end else begin
               case (tok.hdr_code)
                  HDR_SERIAL: begin
                     phase_in = PH_SERIAL;
                     count_in = '0;
                     chars_in = '0;
                  end
                  HDR_VERSION: begin
                     phase_in = PH_VERSION;
                     count_in = '0;
                     chars_in = '0;
                  end
                  HDR_FRAME: begin
                     phase_in = PH_ID;
                     count_in = '0;
                     id_in    = '0;
                     len_in   = '0;
                     data_in  = '0;
                     stamp_in = '0;
                     ext_in   = tok.frame_ext;
                     rtr_in   = tok.frame_rtr;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         PH_SERIAL, PH_VERSION: begin
            // The serial number waits for one closing byte after its four
            // characters; the version is reported on its fourth character.
            if (count_ff < 5'd4) begin
               chars_in = {chars_ff[23:0], tok.rx_byte};
               count_in = count_inc;
            end
            if (count_ff == 5'd4 || (phase_ff == PH_VERSION && count_inc == 5'd4)) begin
               emit           = 1'b1;
               res.event_kind = (phase_ff == PH_SERIAL) ? EV_SERIAL : EV_VERSION;
               res.info_chars = chars_in;
               phase_in       = PH_IDLE;
               count_in       = '0;
            end
         end
         PH_ID: begin
            id_in    = {id_ff[24:0], d};
            count_in = count_inc;
            if (count_inc >= (ext_ff ? 5'd8 : 5'd3)) begin
               phase_in = PH_DLC;
               count_in = '0;
            end
         end
         PH_DLC: begin
            len_in   = dlc;
            count_in = '0;
            phase_in = (rtr_ff || dlc == 4'd0) ? PH_END : PH_DATA;
         end
         PH_DATA: begin
            data_in  = data_ff | ({60'd0, d} << nib_shift);
            count_in = count_inc;
            if (count_inc >= {len_ff, 1'b0}) begin
               phase_in = PH_END;
               count_in = '0;
            end
         end
         PH_END: begin
            if (tok.is_cr) begin
               phase_in          = PH_IDLE;
               emit              = pass_frames;
               res.event_kind    = EV_FRAME;
               res.frame_id      = id_ff;
               res.is_extended   = ext_ff;
               res.is_remote     = rtr_ff;
               res.data_length   = len_ff;
               res.payload       = data_ff;
            end else begin
               stamp_in = {12'd0, d};
               count_in = 5'd1;
               phase_in = PH_STAMP;
            end
         end
         PH_STAMP: begin
            stamp_in = {stamp_ff[11:0], d};
            count_in = count_inc;
            if (count_inc >= 5'd4) begin
               phase_in = PH_STAMP_CR;
               count_in = '0;
            end
         end
         PH_STAMP_CR: begin
            // The closing byte is consumed without a check.
            phase_in          = PH_IDLE;
            emit              = pass_frames;
            res.event_kind    = EV_FRAME;
            res.frame_id      = id_ff;
            res.is_extended   = ext_ff;
            res.is_remote     = rtr_ff;
            res.data_length   = len_ff;
            res.payload       = data_ff;
            res.has_timestamp = 1'b1;
            res.timestamp     = stamp_ff;
         end
         default: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (tok_pop && emit) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (tok_pop) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (tok_pop) begin
         id_ff    <= id_in;
         len_ff   <= len_in;
         data_ff  <= data_in;
         ext_ff   <= ext_in;
         rtr_ff   <= rtr_in;
         stamp_ff <= stamp_in;
         chars_ff <= chars_in;
      end
   end

endmodule

// ===== src/slcan_reply_parser.sv =====
// A byte that completes an event is written into the queue by the edge that accepts it;
// the response register, shown on rsp_, is loaded when the parser pops it from the queue.
// Throughput: one byte per cycle; the parser takes one queued byte each cycle that the
// response register is free or being emptied; req_ready drops while the queue is full.
// Reset clears the parse state, the queue and the response valid, and closes the frame
// pass-through (pass_frames = 0).
// ----------------------------------------------------------------------------
// slcan_reply_parser
// Receive-side parser for the ASCII replies of a serial CAN adapter: ok,
// error, serial number, version and received CAN frame events.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slcan_reply_parser
   import slcan_rp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [28:0] rsp_frame_id,
   output logic        rsp_is_extended,
   output logic        rsp_is_remote,
   output logic [3:0]  rsp_data_length,
   output logic [63:0] rsp_payload,
   output logic        rsp_has_timestamp,
   output logic [15:0] rsp_timestamp,
   output logic [31:0] rsp_info_chars
);

   logic       pass_frames_ff, pass_frames_in;
   token_type  front_token;
   token_type  head_token;
   logic       queue_full;
   logic       queue_not_empty;
   logic       back_pop;
   result_type rsp;

   assign pass_frames_in = csr_wr_en ? csr_wr_data : pass_frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_frames_ff <= 1'b0;
      end else begin
         pass_frames_ff <= pass_frames_in;
      end
   end

   assign req_ready = !queue_full;

   slcan_rp_front u_front (
      .rx_byte (req_rx_byte),
      .token   (front_token)
   );

   slcan_rp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_token (front_token),
      .full       (queue_full),
      .pop        (back_pop),
      .not_empty  (queue_not_empty),
      .head_token (head_token)
   );

   slcan_rp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pass_frames (pass_frames_ff),
      .tok_valid   (queue_not_empty),
      .tok         (head_token),
      .tok_pop     (back_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp)
   );

   assign rsp_event_kind    = rsp.event_kind;
   assign rsp_frame_id      = rsp.frame_id;
   assign rsp_is_extended   = rsp.is_extended;
   assign rsp_is_remote     = rsp.is_remote;
   assign rsp_data_length   = rsp.data_length;
   assign rsp_payload       = rsp.payload;
   assign rsp_has_timestamp = rsp.has_timestamp;
   assign rsp_timestamp     = rsp.timestamp;
   assign rsp_info_chars    = rsp.info_chars;

   `ASSERT_CLK_ALWAYS(a_pop_needs_item, clock, back_pop |-> queue_not_empty, "parser popped an empty queue")
   `ASSERT_CLK(a_dlc_clamped, clock, reset, rsp_valid |-> rsp_data_length <= MAX_DLC, "data length above eight")
   `ASSERT_CLK(a_non_frame_clean, clock, reset, (rsp_valid && rsp_event_kind != EV_FRAME) |-> (rsp_frame_id == '0 && rsp_payload == '0 && !rsp_has_timestamp), "frame fields set on a non-frame event")
   `ASSERT_CLK(a_stamp_zero, clock, reset, (rsp_valid && !rsp_has_timestamp) |-> rsp_timestamp == '0, "timestamp set without a timestamp flag")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for slcan_reply_parser. A short directed run covers
// every header byte and the corner cases of frame parsing. Randomised reply
// streams with stray characters and cut-off frames follow, under changing
// pass_frames settings. A scoreboard predicts each event and checks the
// response channel field by field.
// ----------------------------------------------------------------------------
module tb_top
   import slcan_rp_pkg::*;
();

   localparam int IDLE_PERCENT  = 7;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int PHASE_COUNT   = 6;

   typedef enum logic [3:0] {
      PH_IDLE, PH_SERIAL, PH_VERSION, PH_ID, PH_DLC, PH_DATA, PH_END, PH_STAMP, PH_STAMP_CR
   } parse_phase_e;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_HIGH, FILL_JUNK} digit_fill_e;

   class reply_scoreboard;
      bit           pass_frames;
      parse_phase_e phase;
      int           count;
      logic [28:0]  id_acc;
      logic [3:0]   dlc;
      logic [63:0]  data_acc;
      bit           ext;
      bit           rtr;
      logic [15:0]  stamp_acc;
      logic [31:0]  chars;
      result_type   replies_due[$];
      int unsigned  mismatches;

      function new();
         pass_frames = 1'b0;
         phase       = PH_IDLE;
         count       = 0;
         id_acc      = '0;
         dlc         = '0;
         data_acc    = '0;
         ext         = 1'b0;
         rtr         = 1'b0;
         stamp_acc   = '0;
         chars       = '0;
         mismatches  = 0;
      endfunction

      // Anything that is not a hex digit is taken as zero.
      static function logic [3:0] nibble_of(logic [7:0] c);
         logic [3:0] v;
         v = 4'd0;
         if (c inside {[8'h30:8'h39]}) v = 4'(c - 8'h30);
         else if (c inside {[8'h61:8'h66]}) v = 4'(c - 8'h57);
         else if (c inside {[8'h41:8'h46]}) v = 4'(c - 8'h37);
         return v;
      endfunction

      function void set_pass(bit v);
         pass_frames = v;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      function void open_frame(bit e_flag, bit r_flag);
         phase     = PH_ID;
         count     = 0;
         id_acc    = '0;
         dlc       = '0;
         data_acc  = '0;
         stamp_acc = '0;
         ext       = e_flag;
         rtr       = r_flag;
      endfunction

      function void close_frame(bit stamped);
         result_type r;
         phase = PH_IDLE;
         if (pass_frames) begin
            r               = '0;
            r.event_kind    = EV_FRAME;
            r.frame_id      = id_acc;
            r.is_extended   = ext;
            r.is_remote     = rtr;
            r.data_length   = dlc;
            r.payload       = data_acc;
            r.has_timestamp = stamped;
            r.timestamp     = stamped ? stamp_acc : 16'd0;
            replies_due.push_back(r);
         end
      endfunction

      function void emit_info(logic [2:0] kind);
         result_type r;
         r            = '0;
         r.event_kind = kind;
         r.info_chars = chars;
         replies_due.push_back(r);
         phase = PH_IDLE;
         count = 0;
      endfunction

      function void note_byte(logic [7:0] b);
         logic [3:0] d;
         result_type r;
         d = nibble_of(b);
         case (phase)
            PH_IDLE: begin
               if (b == CHAR_BEL || b == CHAR_CR) begin
                  r            = '0;
                  r.event_kind = (b == CHAR_BEL) ? EV_ERROR : EV_OK;
                  replies_due.push_back(r);
               end else if (b == CHAR_N || b == CHAR_V) begin
                  if (b == CHAR_N) phase = PH_SERIAL;
                  else phase = PH_VERSION;
                  count = 0;
                  chars = '0;
               end else if (b == CHAR_T_L) open_frame(1'b0, 1'b0);
               else if (b == CHAR_T_U) open_frame(1'b1, 1'b0);
               else if (b == CHAR_R_L) open_frame(1'b0, 1'b1);
               else if (b == CHAR_R_U) open_frame(1'b1, 1'b1);
            end
            PH_SERIAL, PH_VERSION: begin
               // The serial reply has one more closing byte, taken without a check.
               if (phase == PH_SERIAL && count == 4) begin
                  emit_info(EV_SERIAL);
               end else begin
                  chars = {chars[23:0], b};
                  count++;
                  if (phase == PH_VERSION && count == 4) emit_info(EV_VERSION);
               end
            end
            PH_ID: begin
               id_acc = {id_acc[24:0], d};
               count++;
               if (count >= (ext ? 8 : 3)) begin
                  phase = PH_DLC;
                  count = 0;
               end
            end
            PH_DLC: begin
               dlc   = (d > 4'd8) ? 4'd8 : d;
               count = 0;
               if (rtr || dlc == 4'd0) phase = PH_END;
               else phase = PH_DATA;
            end
            PH_DATA: begin
               // Each data byte comes high nibble first; byte i sits in bits 8i+7..8i.
               data_acc |= 64'(d) << (8 * (count / 2) + ((count % 2) ? 0 : 4));
               count++;
               if (count >= 2 * dlc) begin
                  phase = PH_END;
                  count = 0;
               end
            end
            PH_END: begin
               if (b == CHAR_CR) begin
                  close_frame(1'b0);
               end else begin
                  stamp_acc = 16'(d);
                  count     = 1;
                  phase     = PH_STAMP;
               end
            end
            PH_STAMP: begin
               stamp_acc = {stamp_acc[11:0], d};
               count++;
               if (count >= 4) begin
                  phase = PH_STAMP_CR;
                  count = 0;
               end
            end
            PH_STAMP_CR: close_frame(1'b1);
            default: begin
               phase = PH_IDLE;
               count = 0;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(result_type got);
         result_type want;
         if (replies_due.size() == 0) begin
            $error("reply with no event waiting: event_kind %0d", got.event_kind);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         compare_field("event_kind", want.event_kind, got.event_kind);
         compare_field("frame_id", want.frame_id, got.frame_id);
         compare_field("is_extended", want.is_extended, got.is_extended);
         compare_field("is_remote", want.is_remote, got.is_remote);
         compare_field("data_length", want.data_length, got.data_length);
         compare_field("payload", want.payload, got.payload);
         compare_field("has_timestamp", want.has_timestamp, got.has_timestamp);
         compare_field("timestamp", want.timestamp, got.timestamp);
         compare_field("info_chars", want.info_chars, got.info_chars);
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [28:0] rsp_frame_id;
   logic        rsp_is_extended;
   logic        rsp_is_remote;
   logic [3:0]  rsp_data_length;
   logic [63:0] rsp_payload;
   logic        rsp_has_timestamp;
   logic [15:0] rsp_timestamp;
   logic [31:0] rsp_info_chars;

   bit              idle_on      = 1'b1;
   int unsigned     sent_items   = 0;
   int unsigned     quiet_cycles = 0;
   logic [7:0]      tx_bytes[$];
   result_type      seen_reply;
   reply_scoreboard reply_sb;

   slcan_reply_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_is_extended   (rsp_is_extended),
      .rsp_is_remote     (rsp_is_remote),
      .rsp_data_length   (rsp_data_length),
      .rsp_payload       (rsp_payload),
      .rsp_has_timestamp (rsp_has_timestamp),
      .rsp_timestamp     (rsp_timestamp),
      .rsp_info_chars    (rsp_info_chars)
   );

   initial forever #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_reply.event_kind    = rsp_event_kind;
         seen_reply.frame_id      = rsp_frame_id;
         seen_reply.is_extended   = rsp_is_extended;
         seen_reply.is_remote     = rsp_is_remote;
         seen_reply.data_length   = rsp_data_length;
         seen_reply.payload       = rsp_payload;
         seen_reply.has_timestamp = rsp_has_timestamp;
         seen_reply.timestamp     = rsp_timestamp;
         seen_reply.info_chars    = rsp_info_chars;
         reply_sb.check_reply(seen_reply);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no item moved for %0d cycles", QUIET_LIMIT);
         $display("** slcan_reply_parser: FAILED **");
         $finish;
      end
   end

   function automatic logic [7:0] hex_char(logic [3:0] v);
      logic [7:0] c;
      if (v < 4'd10) c = 8'h30 + 8'(v);
      else c = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
      return c;
   endfunction

   // Never a CR, so that a stamped frame is not taken for an unstamped one.
   function automatic logic [7:0] digit_char(digit_fill_e fill);
      logic [7:0] c;
      case (fill)
         FILL_ZERO: c = 8'h30;
         FILL_HIGH: c = hex_char(4'hF);
         FILL_JUNK: c = 8'($urandom_range(8'h7A, 8'h67));
         default: begin
            c = hex_char(4'($urandom_range(15)));
            if ($urandom_range(99) < 8) c = 8'($urandom_range(255));
            if (c == CHAR_CR) c = 8'h30;
         end
      endcase
      return c;
   endfunction

   function automatic void add_frame(logic [7:0] hdr, digit_fill_e fill, logic [7:0] dlc_char,
                                     bit stamped, logic [7:0] closer);
      int         n_id;
      int         n_data;
      logic [3:0] len;
      n_id = (hdr == CHAR_T_U || hdr == CHAR_R_U) ? 8 : 3;
      len  = reply_scoreboard::nibble_of(dlc_char);
      if (len > 4'd8) len = 4'd8;
      n_data = (hdr == CHAR_R_L || hdr == CHAR_R_U) ? 0 : 2 * len;
      tx_bytes.push_back(hdr);
      repeat (n_id) tx_bytes.push_back(digit_char(fill));
      tx_bytes.push_back(dlc_char);
      repeat (n_data) tx_bytes.push_back(digit_char(fill));
      if (stamped) begin
         repeat (4) tx_bytes.push_back(digit_char(fill));
         tx_bytes.push_back(closer);
      end else begin
         tx_bytes.push_back(CHAR_CR);
      end
   endfunction

   // A negative fill_byte gives random characters.
   function automatic void add_info(logic [7:0] hdr, int fill_byte);
      tx_bytes.push_back(hdr);
      repeat (4) tx_bytes.push_back((fill_byte < 0) ? 8'($urandom_range(255)) : 8'(fill_byte));
      if (hdr == CHAR_N) tx_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void add_random_reply();
      int         pick;
      int         len_pick;
      logic [7:0] hdr;
      logic [7:0] dlc_char;
      pick = $urandom_range(99);
      if (pick < 55) begin
         case ($urandom_range(3))
            0: hdr = CHAR_T_L;
            1: hdr = CHAR_T_U;
            2: hdr = CHAR_R_L;
            default: hdr = CHAR_R_U;
         endcase
         len_pick = $urandom_range(9);
         if (len_pick < 8) dlc_char = 8'h30 + 8'($urandom_range(8));
         else if (len_pick == 8) dlc_char = hex_char(4'($urandom_range(15, 9)));
         else dlc_char = 8'($urandom_range(255));
         add_frame(hdr, FILL_RANDOM, dlc_char, 1'($urandom_range(1)), 8'($urandom_range(255)));
         // Some frames are cut off, so the parser runs on into whatever follows.
         if ($urandom_range(99) < 8) repeat ($urandom_range(5, 1)) void'(tx_bytes.pop_back());
      end else if (pick < 67) begin
         tx_bytes.push_back($urandom_range(1) ? CHAR_BEL : CHAR_CR);
      end else if (pick < 79) begin
         add_info($urandom_range(1) ? CHAR_N : CHAR_V, -1);
      end else begin
         tx_bytes.push_back(8'($urandom_range(255)));
      end
   endfunction

   // Entered and left just after a falling edge; valid stays up between items.
   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      reply_sb.note_byte(b);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic flush_bytes();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
   endtask

   // Bytes that give no event may still sit in the block, hence the extra cycles.
   task automatic settle();
      req_valid <= 1'b0;
      while (reply_sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pass(input bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      reply_sb.set_pass(v);
   endtask

   initial begin
      int unsigned random_start;
      bit          pass_plan[PHASE_COUNT];
      pass_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      reply_sb  = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_pass(1'b1);

      // Plain events, an unknown header byte and the extremes of the byte range.
      tx_bytes.push_back(CHAR_BEL);
      tx_bytes.push_back(CHAR_CR);
      tx_bytes.push_back(8'h78);
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      add_info(CHAR_V, 8'h00);
      add_info(CHAR_N, 8'hFF);
      // A DLC digit above 8 is clamped; all-ones fields and the 29-bit identifier mask.
      add_frame(CHAR_T_L, FILL_HIGH, 8'h46, 1'b0, CHAR_CR);
      add_frame(CHAR_T_U, FILL_HIGH, 8'h66, 1'b1, 8'h00);
      add_frame(CHAR_R_L, FILL_ZERO, 8'h38, 1'b0, CHAR_CR);
      add_frame(CHAR_R_U, FILL_RANDOM, 8'h33, 1'b1, 8'hFF);
      // Non-hex digits everywhere, including the DLC, read as zero.
      add_frame(CHAR_T_L, FILL_JUNK, 8'h7A, 1'b1, CHAR_CR);
      add_frame(CHAR_T_L, FILL_ZERO, 8'h30, 1'b1, CHAR_CR);
      flush_bytes();
      settle();

      // With pass_frames cleared the frames vanish but other events still come.
      write_pass(1'b0);
      add_frame(CHAR_T_U, FILL_RANDOM, 8'h32, 1'b1, CHAR_CR);
      add_frame(CHAR_R_L, FILL_RANDOM, 8'h31, 1'b0, CHAR_CR);
      tx_bytes.push_back(CHAR_CR);
      flush_bytes();
      settle();

      random_start = sent_items;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_pass(pass_plan[p]);
         idle_on = (p != 3);
         while (sent_items - random_start < RANDOM_ITEMS * (p + 1) / PHASE_COUNT) begin
            add_random_reply();
            flush_bytes();
         end
         settle();
      end
      idle_on = 1'b1;

      repeat (8) @(negedge clock);
      if (reply_sb.mismatches == 0 && reply_sb.pending() == 0) begin
         $display("** slcan_reply_parser: PASSED **");
      end else begin
         $display("** slcan_reply_parser: FAILED **");
      end
      $finish;
   end

endmodule
